### hw/rtl/rigk_pkg.sv
package rigk_pkg;

	localparam int MAX_GROUP = 16;
	localparam int VALUE_W   = 32;
	localparam int ADDR_W    = $clog2(MAX_GROUP);
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int GS_W      = 5;
	localparam int PADDR_W   = 3;

	localparam logic REG_GROUP_SIZE = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} rigk_state_t;

	function automatic logic [CNT_W-1:0] eff_group(input logic [GS_W-1:0] gs);
		logic [CNT_W-1:0] k;
		if (gs == '0) begin
			k = CNT_W'(1);
		end else if (32'(gs) > MAX_GROUP) begin
			k = CNT_W'(MAX_GROUP);
		end else begin
			k = CNT_W'(gs);
		end
		return k;
	endfunction

endpackage

### hw/rtl/reverse_in_groups_of_k_unit.sv
// reverse_in_groups_of_k_unit
// Reorders a stream of list elements: each full group of group_size elements
// comes out reversed, a partial group at the end of a list comes out in order.
// Item channel: value, stream_end with item_valid / item_stall. A request is
// taken at a rising edge with item_valid high and item_stall low.
// Result channel: out_value, run_last, list_done with result_valid /
// result_stall. run_last marks the last result of a run, list_done the final
// element of a list.
// group_size is written over the APB port at byte address 0; 0 acts as 1,
// values above 16 act as 16.
// Elements sit in a 16 x 32 memory with a registered read. An item that
// closes no group is taken without stalling. An item that closes a group of n
// elements, or ends a list, holds item_stall high while the n held elements
// are read out one entry a cycle unless result_stall holds a pending result;
// the first result is read once the state register has entered the read-out.
// The memory read register is the output register: while result_stall holds
// a pending result, the read-out pauses and the payload stays put.
// Reset clears the fill count, the output valid and sets group_size to 1; the
// memory is not cleared, only written entries are ever read.
module reverse_in_groups_of_k_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rigk_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic signed [rigk_pkg::VALUE_W-1:0] value,
	input  logic                            stream_end,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [rigk_pkg::VALUE_W-1:0] out_value,
	output logic                            run_last,
	output logic                            list_done
);
	import rigk_pkg::*;

	logic [VALUE_W-1:0]  mem [MAX_GROUP];
	logic [GS_W-1:0]     group_size_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                rev_q;
	logic                last_q;
	logic [VALUE_W-1:0]  rd_data_q;
	logic                out_valid_q;
	logic                run_last_q;
	logic                list_done_q;
	rigk_state_t         state_q, state_d;

	logic             accept;
	logic             load_en;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] k;
	logic             flush;
	logic             drain_step;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GROUP_SIZE) ? 32'(group_size_q) : '0;

	assign k          = eff_group(group_size_q);
	assign n          = fill_q + CNT_W'(1);
	assign accept     = item_valid && !item_stall;
	assign flush      = (n >= k) || stream_end;
	assign load_en    = !out_valid_q || !result_stall;
	assign drain_step = (state_q == ST_DRAIN) && load_en;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign out_value    = $signed(rd_data_q);
	assign run_last     = run_last_q;
	assign list_done    = list_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GS_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GROUP_SIZE) begin
			group_size_q <= pwdata[GS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && flush) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (load_en && cnt_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			cnt_q       <= '0;
			addr_q      <= '0;
			rev_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			run_last_q  <= 1'b0;
			list_done_q <= 1'b0;
		end else begin
			if (accept) begin
				if (flush) begin
					fill_q <= '0;
					cnt_q  <= n;
					rev_q  <= (n >= k);
					last_q <= stream_end;
					addr_q <= (n >= k) ? fill_q[ADDR_W-1:0] : '0;
				end else begin
					fill_q <= n;
				end
			end
			if (drain_step) begin
				out_valid_q <= 1'b1;
				run_last_q  <= (cnt_q == CNT_W'(1));
				list_done_q <= (cnt_q == CNT_W'(1)) && last_q;
				cnt_q       <= cnt_q - CNT_W'(1);
				addr_q      <= rev_q ? addr_q - ADDR_W'(1) : addr_q + ADDR_W'(1);
			end else if (load_en) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// element store and registered read port
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[fill_q[ADDR_W-1:0]] <= value;
		end
		if (drain_step) begin
			rd_data_q <= mem[addr_q];
		end
	end

endmodule

### hw/rtl/rigk_checker.sv
module rigk_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input logic                            stream_end,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic signed [rigk_pkg::VALUE_W-1:0] out_value,
	input logic                            run_last,
	input logic                            list_done
);
	import rigk_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(out_value) && $stable(run_last)
			&& $stable(list_done))
		else $error("stalled result changed");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && list_done |-> run_last)
		else $error("list end without run end");

	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && stream_end |=> item_stall)
		else $error("list end did not start a read-out");

endmodule

bind reverse_in_groups_of_k_unit rigk_checker u_rigk_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rigk_pkg::*;

	localparam logic [PADDR_W-1:0] GROUP_SIZE_ADDR = PADDR_W'({REG_GROUP_SIZE, 2'b00});
	localparam logic [PADDR_W-1:0] UNUSED_ADDR     = PADDR_W'(4);
	localparam int RANDOM_ITEMS = 330;
	localparam int SETTLE_CYCLES = 8;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      item_valid;
	logic                      item_stall;
	logic signed [VALUE_W-1:0] value;
	logic                      stream_end;
	logic                      result_valid;
	logic                      result_stall;
	logic signed [VALUE_W-1:0] out_value;
	logic                      run_last;
	logic                      list_done;

	typedef struct packed {
		logic [VALUE_W-1:0] data;
		logic               last_of_run;
		logic               end_of_list;
	} reordered_t;

	reordered_t         reordered_q[$];
	logic [VALUE_W-1:0] held_elems[MAX_GROUP];
	int                 held_count;
	logic [GS_W-1:0]    group_size_reg;
	int                 fail_count;
	int                 items_sent;
	bit                 no_idle;

	reverse_in_groups_of_k_unit i_dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int active_group(input logic [GS_W-1:0] gs);
		if (gs == '0) return 1;
		if (gs > MAX_GROUP) return MAX_GROUP;
		return int'(gs);
	endfunction

	// collect one element, queue the reordered run it closes
	function automatic void reorder_item(input logic [VALUE_W-1:0] v, input logic last);
		int         k;
		int         n;
		reordered_t r;
		k = active_group(group_size_reg);
		if (held_count < MAX_GROUP) begin
			held_elems[held_count] = v;
			held_count++;
		end
		n = held_count;
		if (n >= k || last) begin
			for (int i = 0; i < n; i++) begin
				r.data        = (n >= k) ? held_elems[n - 1 - i] : held_elems[i];
				r.last_of_run = (i == n - 1);
				r.end_of_list = last && (i == n - 1);
				reordered_q.push_back(r);
			end
			held_count = 0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: begin
				return 32'h8000_0000;
			end
			1: begin
				return 32'h7FFF_FFFF;
			end
			2: begin
				return 32'h0000_0000;
			end
			3: begin
				return 32'hFFFF_FFFF;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_item(input logic [VALUE_W-1:0] v, input logic last);
		int gap;
		item_valid <= 1'b1;
		value      <= v;
		stream_end <= last;
		do @(posedge clk); while (item_stall);
		reorder_item(v, last);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (reordered_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == GROUP_SIZE_ADDR) group_size_reg = data[GS_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_pass_through();
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_partial_tail();
		write_reg(GROUP_SIZE_ADDR, 32'd3);
		for (int i = 0; i < 4; i++) send_item(rand_value(), i == 3);
		wait_idle();
	endtask

	task automatic test_zero_size();
		write_reg(GROUP_SIZE_ADDR, 32'd0);
		send_item(rand_value(), 1'b1);
		wait_idle();
	endtask

	// size 31 saturates, the group fills exactly on the last element
	task automatic test_saturation();
		write_reg(GROUP_SIZE_ADDR, 32'hFFFF_FFFF);
		for (int i = 0; i < MAX_GROUP; i++) send_item(rand_value(), i == MAX_GROUP - 1);
		wait_idle();
	endtask

	task automatic test_shrink_mid_group();
		write_reg(GROUP_SIZE_ADDR, 32'd4);
		for (int i = 0; i < 3; i++) send_item(rand_value(), 1'b0);
		wait_idle();
		write_reg(GROUP_SIZE_ADDR, 32'd2);
		send_item(rand_value(), 1'b1);
		wait_idle();
	endtask

	task automatic test_unused_address();
		write_reg(UNUSED_ADDR, 32'd1);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);
		wait_idle();
	endtask

	task automatic test_random_lists(input int quota);
		int          target;
		int          phase_end;
		int          len;
		int          k;
		logic [31:0] cfg;
		target = items_sent + quota;
		for (int phase = 0; items_sent < target; phase++) begin
			cfg = $urandom;
			case (phase % 8)
				0: begin
					cfg[GS_W-1:0] = GS_W'(1);
				end
				1: begin
					cfg[GS_W-1:0] = GS_W'(MAX_GROUP);
				end
				2: begin
					cfg[GS_W-1:0] = '1;
				end
				3: begin
					cfg[GS_W-1:0] = '0;
				end
				default: begin
					cfg[GS_W-1:0] = GS_W'($urandom_range(1, 20));
				end
			endcase
			write_reg(GROUP_SIZE_ADDR, cfg);
			no_idle   = (phase % 5 == 4);
			phase_end = items_sent + $urandom_range(25, 55);
			while (items_sent < phase_end && items_sent < target) begin
				k = active_group(group_size_reg);
				if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 40);
				else len = $urandom_range(1, 3 * k);
				for (int i = 0; i < len; i++) begin
					send_item(rand_value(), i == len - 1);
					if (i == len / 2 && (phase == 0 || $urandom_range(0, 5) == 0)) wait_idle();
				end
			end
			// leave an open group across the size change
			if ($urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) send_item(rand_value(), 1'b0);
			end
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		item_valid     = 1'b0;
		value          = '0;
		stream_end     = 1'b0;
		result_stall   = 1'b0;
		held_count     = 0;
		group_size_reg = GS_W'(1);
		fail_count     = 0;
		items_sent     = 0;
		no_idle        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pass_through();
		test_partial_tail();
		test_zero_size();
		test_saturation();
		test_shrink_mid_group();
		test_unused_address();
		test_random_lists(RANDOM_ITEMS);
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && reordered_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat (1 + pick_gap()) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		reordered_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (reordered_q.size() == 0) begin
				$error("unexpected result out_value=%h", out_value);
				fail_count++;
			end else begin
				exp_r = reordered_q.pop_front();
				if (out_value !== exp_r.data) begin
					$error("out_value expected %h actual %h", exp_r.data, out_value);
					fail_count++;
				end
				if (run_last !== exp_r.last_of_run) begin
					$error("run_last expected %b actual %b", exp_r.last_of_run, run_last);
					fail_count++;
				end
				if (list_done !== exp_r.end_of_list) begin
					$error("list_done expected %b actual %b", exp_r.end_of_list, list_done);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
